// File: rtl/core/maze_dfs_backtracker_core_defines.svh
// Assertion macros for the maze carver core.
// Included by modules that check their own logic; needs aclk and aresetn in scope.
`ifndef MAZE_DFS_BACKTRACKER_CORE_DEFINES_SVH
`define MAZE_DFS_BACKTRACKER_CORE_DEFINES_SVH
`ifndef SYNTHESIS
// Check a property on aclk, off while reset is held.
`define MDBT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) prop) else $error(msg);
// Check a property on aclk at every edge, reset included.
`define MDBT_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge aclk) prop) else $error(msg);
`else
`define MDBT_ASSERT(lbl, prop, msg)
`define MDBT_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

// File: rtl/core/mdbt_pkg.sv
// Shared constants for the depth-first maze carver core.
// No dependencies; imported by maze_dfs_backtracker_core.
`default_nettype none

package mdbt_pkg;

    // Grid geometry
    localparam int MAX_SIDE_DEF = 64;
    localparam int GRID_SIDE_W  = 7;
    localparam logic [GRID_SIDE_W-1:0] GRID_SIDE_RST = 7'd16;
    localparam logic [GRID_SIDE_W-1:0] GRID_SIDE_MIN = 7'd2;

    // Configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [0:0] REG_GRID_SIDE = 1'b0;

    // Beat layout
    localparam int DIR_W    = 2;
    localparam int S_DATA_W = 8;
    localparam int EVENT_W  = 3;
    localparam int COORD_W  = 6;
    localparam int DEPTH_W  = 13;
    localparam int M_DATA_W = 40;

    // Directions
    localparam logic [DIR_W-1:0] DIR_UP    = 2'd0;
    localparam logic [DIR_W-1:0] DIR_RIGHT = 2'd1;
    localparam logic [DIR_W-1:0] DIR_DOWN  = 2'd2;
    localparam logic [DIR_W-1:0] DIR_LEFT  = 2'd3;

    // Step outcomes
    localparam logic [EVENT_W-1:0] EV_CARVED   = 3'd0;
    localparam logic [EVENT_W-1:0] EV_MISSED   = 3'd1;
    localparam logic [EVENT_W-1:0] EV_BACKTRACK = 3'd2;
    localparam logic [EVENT_W-1:0] EV_FINISHED = 3'd3;
    localparam logic [EVENT_W-1:0] EV_IDLE     = 3'd4;

endpackage

`default_nettype wire

// File: rtl/core/maze_dfs_backtracker_core.sv
// Depth-first (recursive backtracker) maze carver core with APB configuration.
// Depends on mdbt_pkg and maze_dfs_backtracker_core_defines.svh.
// ---------------------------------------------------------------------------
// Usage
//   s_* stream: one beat per step, s_tdata[1:0] is a random direction
//     (up, right, down, left). Each beat advances the carver by one step
//     from cell (0,0) outward.
//   m_* stream: one beat per input beat, m_tuser gives the step outcome
//     (carved, missed draw, backtracked, finished, idle after finish) and
//     m_tdata the from/to coordinates, the carved side and the stack depth.
//   APB: register 0 at address 0 holds the grid side (reset 16); values
//     below 2 act as 2, above MAX_SIDE as MAX_SIDE. Write only while idle.
// Step sequence
//   A beat is taken while idle or as the previous step commits, so a new
//   beat waits until the last step decides. Each step reads three rows of
//   the visited map (row above, row below, own row) through the map's
//   single read port, then decides, loads the output register and writes
//   back in the cycle that can take the next beat.
// Reset
//   aresetn is synchronous, active low. After it the visited map is wiped
//   one row per cycle, all MAX_SIDE rows, with s_tready low; APB stays open.
// Stalls
//   A result waits in the output register while m_tready is low; the step
//   behind it holds in its decide cycle, so nothing is lost or repeated.
// ---------------------------------------------------------------------------
`default_nettype none
`include "maze_dfs_backtracker_core_defines.svh"

module maze_dfs_backtracker_core
    import mdbt_pkg::*;
#(
    parameter int MAX_SIDE = MAX_SIDE_DEF
) (
    input  wire                     aclk,
    input  wire                     aresetn,
    // input stream
    input  wire                     s_tvalid,
    output logic                    s_tready,
    input  wire  [S_DATA_W-1:0]     s_tdata,   // [1:0] random_direction
    // result stream
    output logic                    m_tvalid,
    input  wire                     m_tready,
    output logic [M_DATA_W-1:0]     m_tdata,   // from_x, from_y, to_x, to_y,
                                               // carved_side, depth_now, pad
    output logic [EVENT_W-1:0]      m_tuser,   // event_res
    // configuration
    input  wire                     psel,
    input  wire                     penable,
    input  wire                     pwrite,
    input  wire  [APB_ADDR_W-1:0]   paddr,
    input  wire  [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]   prdata,
    output logic                    pready
);

    localparam int XW    = $clog2(MAX_SIDE);
    localparam int CW    = 2 * XW;
    localparam int CELLS = MAX_SIDE * MAX_SIDE;
    localparam int AW    = $clog2(CELLS);
    localparam int LW    = $clog2(CELLS + 1);
    localparam int SW    = ($clog2(MAX_SIDE + 1) > GRID_SIDE_W) ?
                           $clog2(MAX_SIDE + 1) : GRID_SIDE_W;
    localparam logic [XW-1:0] XMAX = XW'(MAX_SIDE - 1);

    typedef enum logic [1:0] {ST_IDLE, ST_UP, ST_DOWN, ST_DECIDE} state_t;

    // ------------------------------------------------------------------
    // Configuration register
    // ------------------------------------------------------------------
    logic [GRID_SIDE_W-1:0] grid_side_reg;
    logic                   cfg_sel;
    logic [SW-1:0]          side_use;

    assign pready  = 1'b1;
    assign cfg_sel = (paddr[APB_ADDR_W-1:2] == REG_GRID_SIDE);
    assign prdata  = cfg_sel ? APB_DATA_W'(grid_side_reg) : '0;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_side_reg <= GRID_SIDE_RST;
        end else if (psel && penable && pwrite && pready && cfg_sel) begin
            grid_side_reg <= pwdata[GRID_SIDE_W-1:0];
        end
    end

    // Clamp the side into [2, MAX_SIDE]
    always_comb begin
        if (grid_side_reg < GRID_SIDE_MIN) begin
            side_use = SW'(GRID_SIDE_MIN);
        end else if (SW'(grid_side_reg) > SW'(MAX_SIDE)) begin
            side_use = SW'(MAX_SIDE);
        end else begin
            side_use = SW'(grid_side_reg);
        end
    end

    // ------------------------------------------------------------------
    // Control and step registers
    // ------------------------------------------------------------------
    state_t                 state_reg;
    logic                   clear_reg;
    logic [XW-1:0]          clr_cnt_reg;
    logic [XW-1:0]          cur_x_reg, cur_y_reg;
    logic [LW-1:0]          level_reg;
    logic                   done_reg;
    logic [DIR_W-1:0]       dir_reg;
    logic                   up_vis_reg, down_vis_reg;
    logic                   m_tvalid_reg;
    logic [M_DATA_W-1:0]    m_tdata_reg;
    logic [EVENT_W-1:0]     m_tuser_reg;

    logic accept, out_free, fire;

    assign out_free = !m_tvalid_reg || m_tready;
    assign fire     = (state_reg == ST_DECIDE) && out_free;
    assign s_tready = !clear_reg && ((state_reg == ST_IDLE) || fire);
    assign accept   = s_tvalid && s_tready;

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

    // ------------------------------------------------------------------
    // Visited map: one row of MAX_SIDE bits per entry, 1W1R
    // ------------------------------------------------------------------
    logic [MAX_SIDE-1:0] vis_mem [MAX_SIDE];
    logic [MAX_SIDE-1:0] vis_rdata_reg, fwd_data_reg, vis_row, vis_wdata;
    logic                fwd_hit_reg;
    logic                vis_we, vis_re;
    logic [XW-1:0]       vis_waddr, vis_raddr;

    always_ff @(posedge aclk) begin
        if (vis_we) begin
            vis_mem[vis_waddr] <= vis_wdata;
        end
        if (vis_re) begin
            vis_rdata_reg <= vis_mem[vis_raddr];
            fwd_hit_reg   <= vis_we && (vis_waddr == vis_raddr);
            fwd_data_reg  <= vis_wdata;
        end
    end

    // Take the written row when a read hit the row written in the same cycle
    assign vis_row = fwd_hit_reg ? fwd_data_reg : vis_rdata_reg;

    // ------------------------------------------------------------------
    // Return stack: single port, read in ST_UP, written in ST_DECIDE
    // ------------------------------------------------------------------
    logic [CW-1:0] stk_mem [CELLS];
    logic [CW-1:0] stk_rdata_reg;
    logic          stk_we, stk_re;
    logic [AW-1:0] stk_raddr;

    assign stk_re    = (state_reg == ST_UP);
    assign stk_raddr = AW'(level_reg - LW'(1));

    always_ff @(posedge aclk) begin
        if (stk_we) begin
            stk_mem[level_reg[AW-1:0]] <= {cur_y_reg, cur_x_reg};
        end else if (stk_re) begin
            stk_rdata_reg <= stk_mem[stk_raddr];
        end
    end

    // ------------------------------------------------------------------
    // Step decision, evaluated in ST_DECIDE with all three rows at hand
    // ------------------------------------------------------------------
    logic [3:0]         nb;
    logic [XW-1:0]      x_r, x_l;
    logic               right_vis, left_vis;
    logic [EVENT_W-1:0] dec_ev;
    logic [XW-1:0]      dec_x, dec_y;
    logic [DIR_W-1:0]   dec_side;
    logic [LW-1:0]      dec_level;
    logic               dec_done, dec_push;
    logic [XW-1:0]      cur_y_nx, up_row, cur_row_sel;

    assign x_r       = (cur_x_reg == XMAX) ? cur_x_reg : cur_x_reg + XW'(1);
    assign x_l       = (cur_x_reg == '0) ? cur_x_reg : cur_x_reg - XW'(1);
    assign right_vis = vis_row[x_r];
    assign left_vis  = vis_row[x_l];

    always_comb begin
        nb[DIR_UP]    = (cur_y_reg != '0) && !up_vis_reg;
        nb[DIR_RIGHT] = ((SW'(cur_x_reg) + SW'(1)) < side_use) && !right_vis;
        nb[DIR_DOWN]  = ((SW'(cur_y_reg) + SW'(1)) < side_use) && !down_vis_reg;
        nb[DIR_LEFT]  = (cur_x_reg != '0) && !left_vis;

        dec_ev    = EV_IDLE;
        dec_x     = cur_x_reg;
        dec_y     = cur_y_reg;
        dec_side  = DIR_UP;
        dec_level = level_reg;
        dec_done  = done_reg;
        dec_push  = 1'b0;

        if (done_reg) begin
            dec_ev = EV_IDLE;
        end else if (nb == '0) begin
            if (level_reg != '0) begin
                // Dead end: pop the cell we came from
                dec_level = level_reg - LW'(1);
                dec_x     = stk_rdata_reg[XW-1:0];
                dec_y     = stk_rdata_reg[CW-1:XW];
                dec_ev    = EV_BACKTRACK;
            end else begin
                dec_done = 1'b1;
                dec_ev   = EV_FINISHED;
            end
        end else if (nb[dir_reg]) begin
            // Carve: push unless the stack is full, then move
            dec_push = (level_reg < LW'(CELLS));
            if (dec_push) begin
                dec_level = level_reg + LW'(1);
            end
            case (dir_reg)
                DIR_UP:    dec_y = cur_y_reg - XW'(1);
                DIR_RIGHT: dec_x = cur_x_reg + XW'(1);
                DIR_DOWN:  dec_y = cur_y_reg + XW'(1);
                DIR_LEFT:  dec_x = cur_x_reg - XW'(1);
                default:   dec_x = cur_x_reg;
            endcase
            dec_side = dir_reg;
            dec_ev   = EV_CARVED;
        end else begin
            dec_ev = EV_MISSED;
        end
    end

    assign stk_we = fire && dec_push;

    // Row addresses: the first read of a step is issued as its beat is
    // taken, possibly in the cycle the previous step commits its move.
    assign cur_y_nx    = fire ? dec_y : cur_y_reg;
    assign up_row      = (cur_y_nx == '0) ? cur_y_nx : cur_y_nx - XW'(1);
    assign cur_row_sel = (cur_y_reg == XMAX) ? cur_y_reg : cur_y_reg + XW'(1);

    always_comb begin
        vis_re    = accept || (state_reg == ST_UP) || (state_reg == ST_DOWN);
        vis_raddr = cur_y_reg;
        if (accept) begin
            vis_raddr = up_row;
        end else if (state_reg == ST_UP) begin
            vis_raddr = cur_row_sel;
        end
        vis_we    = clear_reg || (fire && !done_reg);
        vis_waddr = clear_reg ? clr_cnt_reg : cur_y_reg;
        vis_wdata = clear_reg ? '0 : (vis_row | (MAX_SIDE'(1) << cur_x_reg));
    end

    // ------------------------------------------------------------------
    // Sequencer, step state and output register
    // ------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            clear_reg    <= 1'b1;
            clr_cnt_reg  <= '0;
            cur_x_reg    <= '0;
            cur_y_reg    <= '0;
            level_reg    <= '0;
            done_reg     <= 1'b0;
            dir_reg      <= DIR_UP;
            up_vis_reg   <= 1'b0;
            down_vis_reg <= 1'b0;
            m_tvalid_reg <= 1'b0;
            m_tdata_reg  <= '0;
            m_tuser_reg  <= EV_IDLE;
        end else begin
            // Wipe the visited map one row per cycle
            if (clear_reg) begin
                clr_cnt_reg <= clr_cnt_reg + XW'(1);
                if (clr_cnt_reg == XMAX) begin
                    clear_reg <= 1'b0;
                end
            end

            // Load on a committed step, drop once the beat is taken
            if (fire) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        state_reg <= ST_UP;
                    end
                end
                ST_UP: begin
                    up_vis_reg <= vis_row[cur_x_reg];
                    state_reg  <= ST_DOWN;
                end
                ST_DOWN: begin
                    down_vis_reg <= vis_row[cur_x_reg];
                    state_reg    <= ST_DECIDE;
                end
                ST_DECIDE: begin
                    if (fire) begin
                        cur_x_reg    <= dec_x;
                        cur_y_reg    <= dec_y;
                        level_reg    <= dec_level;
                        done_reg     <= dec_done;
                        m_tuser_reg  <= dec_ev;
                        m_tdata_reg  <= M_DATA_W'({DEPTH_W'(dec_level), dec_side,
                                                   COORD_W'(dec_y), COORD_W'(dec_x),
                                                   COORD_W'(cur_y_reg),
                                                   COORD_W'(cur_x_reg)});
                        state_reg    <= accept ? ST_UP : ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (accept) begin
                dir_reg <= s_tdata[DIR_W-1:0];
            end
        end
    end

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
    `MDBT_ASSERT(a_accept_starts_step, accept |=> (state_reg == ST_UP), "beat taken, no step")
    `MDBT_ASSERT(a_level_bound, level_reg <= LW'(CELLS), "stack level past capacity")
    `MDBT_ASSERT(a_done_sticky, done_reg |=> done_reg, "finish flag dropped")
    `MDBT_ASSERT(a_clear_quiet, clear_reg |-> (state_reg == ST_IDLE && !m_tvalid_reg), "busy in wipe")
    `MDBT_ASSERT_ALWAYS(a_pready_high, pready, "pready dropped")

endmodule

`default_nettype wire
